[hdl/assert_macros.svh]
// Assertion helpers shared by the string unescaper modules.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition never occurs at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes of the JSON string unescaper: one result item and
// the bundle of up to four items that one input byte produces.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int MAX_ITEMS = 4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_QUOTE  = 3'd1;
    localparam logic [2:0] ST_UNCLOSED  = 3'd2;
    localparam logic [2:0] ST_CTRL      = 3'd3;
    localparam logic [2:0] ST_ESC_OPEN  = 3'd4;
    localparam logic [2:0] ST_ESC_BAD   = 3'd5;
    localparam logic [2:0] ST_HEX_SHORT = 3'd6;
    localparam logic [2:0] ST_HEX_BAD   = 3'd7;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [2:0] status;
    } item_t;

    typedef struct packed {
        item_t [MAX_ITEMS-1:0] items;
        logic  [2:0]           count;   // 1 to 4 on every stored bundle
    } bundle_t;

endpackage

[hdl/json_string_unescape_utf8.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming JSON string unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// One text byte is accepted per cycle while the bundle queue has room. Each
// byte yields zero to four result items, kept together as one bundle in a
// QDEPTH-entry queue; the output side delivers one item per cycle while pop
// is held, and the sustained input rate is one byte per cycle as long as the
// average item count per byte stays at or below one. A result reaches the
// ports from the queue registers once the bundles ahead of it are popped.
// full reflects only the queue fill.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
#(
    parameter int QDEPTH = 4    // 2 or more
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_mark,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_done,
    output logic [2:0] status,
    output logic       last
);

    logic             in_acc;
    logic             wr;
    jsu_pkg::bundle_t wr_bundle;
    jsu_pkg::bundle_t head;
    logic             q_empty;
    logic             q_pop;

    assign in_acc = push && !full;

    jsu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_acc   (in_acc),
        .in_byte  (in_byte),
        .end_mark (end_mark),
        .wr       (wr),
        .bundle   (wr_bundle)
    );

    jsu_queue #(.DEPTH(QDEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wr_data (wr_bundle),
        .rd      (q_pop),
        .rd_data (head),
        .full    (full),
        .q_empty (q_empty)
    );

    jsu_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .string_done (string_done),
        .status      (status),
        .last        (last)
    );

endmodule

[hdl/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Parser state machine. Classifies each accepted byte and builds the bundle
// of result items that the byte causes, including UTF-8 expansion of \u
// escapes and surrogate pair joining.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_acc,
    input  logic [7:0]       in_byte,
    input  logic             end_mark,
    output logic             wr,
    output jsu_pkg::bundle_t bundle
);

    localparam logic [2:0] M_IDLE       = 3'd0;
    localparam logic [2:0] M_STR        = 3'd1;
    localparam logic [2:0] M_ESC        = 3'd2;
    localparam logic [2:0] M_HEX1       = 3'd3;
    localparam logic [2:0] M_AFTER_HIGH = 3'd4;
    localparam logic [2:0] M_PAIR_BS    = 3'd5;
    localparam logic [2:0] M_HEX2       = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [5:0]  HI_TAG    = 6'b110110;   // 0xD800..0xDBFF
    localparam logic [5:0]  LO_TAG    = 6'b110111;   // 0xDC00..0xDFFF
    localparam logic [20:0] CP_REPL   = 21'h00FFFD;
    localparam logic [20:0] CP_SUPP   = 21'h010000;

    typedef struct packed {
        logic              en;
        jsu_pkg::item_t    it;
        logic [2:0]        nm;
    } step_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } utf8_t;

    function automatic jsu_pkg::item_t mk_item(logic [7:0] b, logic v, logic d, logic [2:0] s);
        jsu_pkg::item_t it;
        it.out_byte    = b;
        it.byte_valid  = v;
        it.string_done = d;
        it.status      = s;
        return it;
    endfunction

    // byte inside the string body
    function automatic step_t str_step(logic [7:0] c);
        step_t s;
        s = '0;
        if (c == CH_QUOTE)
        begin
            s.en = 1'b1;
            s.it = mk_item(8'h00, 1'b0, 1'b1, jsu_pkg::ST_OK);
            s.nm = M_IDLE;
        end
        else if (c == CH_BSL)
        begin
            s.nm = M_ESC;
        end
        else if (c < CH_SPACE)
        begin
            s.en = 1'b1;
            s.it = mk_item(8'h00, 1'b0, 1'b0, jsu_pkg::ST_CTRL);
            s.nm = M_IDLE;
        end
        else
        begin
            s.en = 1'b1;
            s.it = mk_item(c, 1'b1, 1'b0, jsu_pkg::ST_OK);
            s.nm = M_STR;
        end
        return s;
    endfunction

    // byte after a backslash
    function automatic step_t esc_step(logic [7:0] c);
        step_t      s;
        logic [7:0] r;
        s = '0;
        r = 8'h00;
        s.nm = M_STR;
        s.en = 1'b1;
        case (c)
            CH_QUOTE: r = CH_QUOTE;
            CH_BSL:   r = CH_BSL;
            CH_SLASH: r = CH_SLASH;
            8'h62:    r = 8'h08;     // b
            8'h66:    r = 8'h0C;     // f
            8'h6E:    r = 8'h0A;     // n
            8'h72:    r = 8'h0D;     // r
            8'h74:    r = 8'h09;     // t
            CH_U:
            begin
                s.en = 1'b0;
                s.nm = M_HEX1;
            end
            default:
            begin
                s.nm = M_IDLE;
                s.it = mk_item(8'h00, 1'b0, 1'b0, jsu_pkg::ST_ESC_BAD);
            end
        endcase
        if (s.en && (s.nm == M_STR))
        begin
            s.it = mk_item(r, 1'b1, 1'b0, jsu_pkg::ST_OK);
        end
        return s;
    endfunction

    // bit 4 set marks a non-hex byte
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = 5'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = 5'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = 5'(c - 8'h37);
        end
        else
        begin
            d = 5'h10;
        end
        return d;
    endfunction

    function automatic utf8_t utf8_enc(logic [20:0] cp);
        utf8_t e;
        e = '0;
        if (cp <= 21'h7F)
        begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end
        else if (cp <= 21'h7FF)
        begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
        end
        else if (cp <= 21'hFFFF)
        begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
        end
        else
        begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

    logic [2:0]     mode_reg, mode_next;
    logic [15:0]    hex_reg, hex_next;
    logic [9:0]     high_reg, high_next;
    logic [1:0]     dig_reg, dig_next;

    logic           cp_en;
    logic [20:0]    cp_val;
    logic           tail_en;
    jsu_pkg::item_t tail_it;
    step_t          st;
    logic [4:0]     dig;
    logic [15:0]    code;
    utf8_t          enc;
    logic [2:0]     ncp;

    always_comb
    begin
        mode_next = mode_reg;
        hex_next  = hex_reg;
        high_next = high_reg;
        dig_next  = dig_reg;
        cp_en     = 1'b0;
        cp_val    = CP_REPL;
        tail_en   = 1'b0;
        tail_it   = '0;
        st        = '0;
        dig       = hex_digit(in_byte);
        code      = {hex_reg[11:0], dig[3:0]};

        case (mode_reg)
            M_STR:
            begin
                if (end_mark)
                begin
                    tail_en   = 1'b1;
                    tail_it   = mk_item(8'h00, 1'b0, 1'b0, jsu_pkg::ST_UNCLOSED);
                    mode_next = M_IDLE;
                end
                else
                begin
                    st        = str_step(in_byte);
                    tail_en   = st.en;
                    tail_it   = st.it;
                    mode_next = st.nm;
                end
            end
            M_ESC:
            begin
                if (end_mark)
                begin
                    tail_en   = 1'b1;
                    tail_it   = mk_item(8'h00, 1'b0, 1'b0, jsu_pkg::ST_ESC_OPEN);
                    mode_next = M_IDLE;
                end
                else
                begin
                    st        = esc_step(in_byte);
                    tail_en   = st.en;
                    tail_it   = st.it;
                    mode_next = st.nm;
                    if (in_byte == CH_U)
                    begin
                        hex_next = '0;
                        dig_next = '0;
                    end
                end
            end
            M_HEX1, M_HEX2:
            begin
                if (end_mark || dig[4])
                begin
                    tail_en   = 1'b1;
                    tail_it   = mk_item(8'h00, 1'b0, 1'b0,
                                        end_mark ? jsu_pkg::ST_HEX_SHORT : jsu_pkg::ST_HEX_BAD);
                    mode_next = M_IDLE;
                end
                else
                begin
                    hex_next = code;
                    dig_next = dig_reg + 2'd1;    // wraps to zero after the fourth digit
                    if (dig_reg == 2'd3)
                    begin
                        if ((mode_reg == M_HEX1) && (code[15:10] == HI_TAG))
                        begin
                            high_next = code[9:0];
                            mode_next = M_AFTER_HIGH;
                        end
                        else
                        begin
                            cp_en     = 1'b1;
                            mode_next = M_STR;
                            if (mode_reg == M_HEX1)
                            begin
                                cp_val = (code[15:10] == LO_TAG) ? CP_REPL : {5'b0, code};
                            end
                            else
                            begin
                                cp_val = (code[15:10] == LO_TAG)
                                       ? CP_SUPP + {1'b0, high_reg, code[9:0]}
                                       : CP_REPL;
                            end
                        end
                    end
                end
            end
            M_AFTER_HIGH:
            begin
                if (!end_mark && (in_byte == CH_BSL))
                begin
                    mode_next = M_PAIR_BS;
                end
                else
                begin
                    cp_en = 1'b1;
                    if (end_mark)
                    begin
                        tail_en   = 1'b1;
                        tail_it   = mk_item(8'h00, 1'b0, 1'b0, jsu_pkg::ST_UNCLOSED);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        st        = str_step(in_byte);
                        tail_en   = st.en;
                        tail_it   = st.it;
                        mode_next = st.nm;
                    end
                end
            end
            M_PAIR_BS:
            begin
                if (!end_mark && (in_byte == CH_U))
                begin
                    mode_next = M_HEX2;
                    hex_next  = '0;
                    dig_next  = '0;
                end
                else
                begin
                    cp_en = 1'b1;
                    if (end_mark)
                    begin
                        tail_en   = 1'b1;
                        tail_it   = mk_item(8'h00, 1'b0, 1'b0, jsu_pkg::ST_ESC_OPEN);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        st        = esc_step(in_byte);
                        tail_en   = st.en;
                        tail_it   = st.it;
                        mode_next = st.nm;
                    end
                end
            end
            default:
            begin
                mode_next = M_IDLE;
                if (!end_mark)
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        mode_next = M_STR;
                    end
                    else
                    begin
                        tail_en = 1'b1;
                        tail_it = mk_item(8'h00, 1'b0, 1'b0, jsu_pkg::ST_NO_QUOTE);
                    end
                end
            end
        endcase
    end

    // pack code point bytes first, then the trailing item
    always_comb
    begin
        enc = utf8_enc(cp_val);
        ncp = cp_en ? enc.len : 3'd0;
        for (int i = 0; i < jsu_pkg::MAX_ITEMS; i++)
        begin
            bundle.items[i] = '0;
            if (cp_en && (3'(i) < enc.len))
            begin
                bundle.items[i] = mk_item(enc.bytes[i], 1'b1, 1'b0, jsu_pkg::ST_OK);
            end
            else if (tail_en && (3'(i) == ncp))
            begin
                bundle.items[i] = tail_it;
            end
        end
        bundle.count = ncp + {2'b00, tail_en};
    end

    assign wr = in_acc && (bundle.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            hex_reg  <= '0;
            high_reg <= '0;
            dig_reg  <= '0;
        end
        else if (in_acc)
        begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            high_reg <= high_next;
            dig_reg  <= dig_next;
        end
    end

    `ASSERT_NEVER(a_front_count, wr && (bundle.count > 3'd4), "bundle holds more than four items")
    `ASSERT_CLK(a_front_done, (wr && tail_en && tail_it.string_done) |=> (mode_reg == M_IDLE), "closing quote did not return to idle")

endmodule

[hdl/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue
// Small flip-flop queue of result bundles between the parser and the
// output serializer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  jsu_pkg::bundle_t wr_data,
    input  logic             rd,
    output jsu_pkg::bundle_t rd_data,
    output logic             full,
    output logic             q_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::bundle_t mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_wr, do_rd;

    function automatic logic [AW-1:0] bump(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign full    = (cnt_reg == CW'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    `ASSERT_NEVER(a_queue_over, cnt_reg > CW'(DEPTH), "queue count beyond depth")

endmodule

[hdl/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Output serializer. Walks the items of the bundle at the queue head, one
// item per accepted pop, and marks the final item of each bundle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  jsu_pkg::bundle_t head,
    input  logic             q_empty,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             string_done,
    output logic [2:0]       status,
    output logic             last
);

    logic [1:0]     idx_reg;
    jsu_pkg::item_t cur;
    logic           take;

    assign cur         = head.items[idx_reg];
    assign empty       = q_empty;
    assign out_byte    = cur.out_byte;
    assign byte_valid  = cur.byte_valid;
    assign string_done = cur.string_done;
    assign status      = cur.status;
    assign last        = ((3'(idx_reg) + 3'd1) == head.count);
    assign take        = pop && !q_empty;
    assign q_pop       = take && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (take)
        begin
            // drop the bundle after its final item, else advance
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    `ASSERT_NEVER(a_back_idx, !q_empty && (3'(idx_reg) >= head.count), "item index past bundle end")
    `ASSERT_CLK(a_back_restart, $past(q_pop) |-> (idx_reg == 2'd0), "next bundle not started at its first item")

endmodule
